[hw/rtl/srd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_pkg - shared types for the signed restoring divider
// Control word that travels alongside each beat through the cell chain.
// ----------------------------------------------------------------------------
package srd_pkg;

	// Per-stage control: occupancy plus the sign and zero-divisor marks
	// that are settled at the front and only applied at the back.
	typedef struct packed {
		logic valid;
		logic neg;
		logic dbz;
	} srd_ctl_t;

	localparam srd_ctl_t SRD_CTL_IDLE = '{valid: 1'b0, neg: 1'b0, dbz: 1'b0};

endpackage

[hw/rtl/srd_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_cell - one restoring shift-and-subtract step
// Shifts the next dividend bit into the partial remainder, trial-subtracts the
// divisor and shifts the quotient bit into the low end of the work word.
// ----------------------------------------------------------------------------
module srd_cell import srd_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  srd_ctl_t         ctl_in,
	input  logic [WIDTH-1:0] rem_in,
	input  logic [WIDTH-1:0] work_in,
	input  logic [WIDTH-1:0] den_in,
	input  logic             ready_next,
	output logic             ready,
	output srd_ctl_t         ctl_out,
	output logic [WIDTH-1:0] rem_out,
	output logic [WIDTH-1:0] work_out,
	output logic [WIDTH-1:0] den_out
);

	srd_ctl_t         ctl_q;
	logic [WIDTH-1:0] rem_q;
	logic [WIDTH-1:0] work_q;
	logic [WIDTH-1:0] den_q;

	logic [WIDTH:0]   trial;
	logic [WIDTH+1:0] diff;
	logic             ge;
	logic [WIDTH-1:0] rem_next;
	logic [WIDTH-1:0] work_next;

	// bubble collapse: take a beat when empty or when the neighbor moves on
	assign ready = !ctl_q.valid || ready_next;

	always_comb begin
		trial     = {rem_in, work_in[WIDTH-1]};
		diff      = {1'b0, trial} - {2'b00, den_in};
		ge        = !diff[WIDTH+1];
		rem_next  = ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
		work_next = {work_in[WIDTH-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= SRD_CTL_IDLE;
		end else if (ready) begin
			ctl_q <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && ctl_in.valid) begin
			rem_q  <= rem_next;
			work_q <= work_next;
			den_q  <= den_in;
		end
	end

	assign ctl_out  = ctl_q;
	assign rem_out  = rem_q;
	assign work_out = work_q;
	assign den_out  = den_q;

endmodule

[hw/rtl/signed_restoring_divider.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_restoring_divider - pipelined signed integer divider
// Quotient truncated toward zero; zero divisor raises div_by_zero.
// ----------------------------------------------------------------------------
//  port group | handshake            | payload
//  -----------+----------------------+------------------------------
//  in         | in_valid / in_stall  | dividend, divisor
//  out        | out_valid / out_stall| quotient, div_by_zero
//
//  The pipeline holds one operand-magnitude stage, WIDTH subtract
//  cells (one quotient bit each) and one sign-fix output register.
//  Throughput is one beat per cycle; the cell chain is fully pipelined.
//  Each stage holds while its successor is full and stalled, and empty
//  stages fill behind a stalled output, so in_stall rises only when every
//  stage holds a beat. arst_n clears stage occupancy only.
// ----------------------------------------------------------------------------
module signed_restoring_divider import srd_pkg::*; #(
	parameter int WIDTH = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [WIDTH-1:0] dividend,
	input  logic [WIDTH-1:0] divisor,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [WIDTH-1:0] quotient,
	output logic             div_by_zero
);

	// chain taps: index k feeds cell k, index WIDTH feeds the output stage
	srd_ctl_t         ctl_c  [0:WIDTH];
	logic [WIDTH-1:0] rem_c  [0:WIDTH];
	logic [WIDTH-1:0] work_c [0:WIDTH];
	logic [WIDTH-1:0] den_c  [0:WIDTH];
	logic             rdy_c  [0:WIDTH];

	// front stage: magnitudes and sign
	srd_ctl_t         ctl_s1;
	logic [WIDTH-1:0] num_s1;
	logic [WIDTH-1:0] den_s1;
	logic             rdy_s1;

	// output stage
	srd_ctl_t         ctl_s2;
	logic [WIDTH-1:0] quot_s2;

	logic [WIDTH-1:0] num_mag;
	logic [WIDTH-1:0] den_mag;

	// most negative value negates to itself, which is its correct magnitude
	assign num_mag = dividend[WIDTH-1] ? (~dividend + WIDTH'(1)) : dividend;
	assign den_mag = divisor[WIDTH-1]  ? (~divisor  + WIDTH'(1)) : divisor;

	assign rdy_s1   = !ctl_s1.valid || rdy_c[0];
	assign in_stall = !rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= SRD_CTL_IDLE;
		end else if (rdy_s1) begin
			ctl_s1.valid <= in_valid;
			ctl_s1.neg   <= dividend[WIDTH-1] ^ divisor[WIDTH-1];
			ctl_s1.dbz   <= (divisor == '0);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			num_s1 <= num_mag;
			den_s1 <= den_mag;
		end
	end

	assign ctl_c[0]  = ctl_s1;
	assign rem_c[0]  = '0;
	assign work_c[0] = num_s1;
	assign den_c[0]  = den_s1;

	// cell k resolves quotient bit WIDTH-1-k
	for (genvar k = 0; k < WIDTH; k++) begin : g_cell
		srd_cell #(
			.WIDTH(WIDTH)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl_c[k]),
			.rem_in    (rem_c[k]),
			.work_in   (work_c[k]),
			.den_in    (den_c[k]),
			.ready_next(rdy_c[k+1]),
			.ready     (rdy_c[k]),
			.ctl_out   (ctl_c[k+1]),
			.rem_out   (rem_c[k+1]),
			.work_out  (work_c[k+1]),
			.den_out   (den_c[k+1])
		);
	end

	// output register; the last cell's work word is the quotient magnitude
	assign rdy_c[WIDTH] = !ctl_s2.valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= SRD_CTL_IDLE;
		end else if (rdy_c[WIDTH]) begin
			ctl_s2 <= ctl_c[WIDTH];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_c[WIDTH] && ctl_c[WIDTH].valid) begin
			quot_s2 <= ctl_c[WIDTH].neg ? (~work_c[WIDTH] + WIDTH'(1)) : work_c[WIDTH];
		end
	end

	assign out_valid   = ctl_s2.valid;
	assign quotient    = quot_s2;
	assign div_by_zero = ctl_s2.dbz;

endmodule

[hw/rtl/srd_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srd_checker - port-level checks for the signed restoring divider
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module srd_checker #(
	parameter int WIDTH = 32
) (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_stall,
	input logic [WIDTH-1:0] dividend,
	input logic [WIDTH-1:0] divisor,
	input logic             out_valid,
	input logic             out_stall,
	input logic [WIDTH-1:0] quotient,
	input logic             div_by_zero
);

	// a held result beat stays presented
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(quotient) && $stable(div_by_zero))
		else $error("result beat changed while stalled");

	// input backpressure only once the whole chain is full behind a stalled output
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("in_stall raised with room in the pipeline");

	// zero divisor gives a quotient of plus or minus one
	a_dbz_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && div_by_zero |-> quotient == '1 || quotient == WIDTH'(1))
		else $error("zero-divisor quotient not plus or minus one");

	// an accepted operand beat carries known bits
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |-> !$isunknown(dividend) && !$isunknown(divisor))
		else $error("unknown operand accepted");

endmodule

bind signed_restoring_divider srd_checker #(.WIDTH(WIDTH)) u_srd_checker (.*);

[tb/signed_restoring_divider_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_restoring_divider_tb - self-checking bench for the signed divider
// Pushes operand pairs through the valid/stall front, predicts each quotient
// the table does not fix with a bit-serial restoring divide of its own, and
// compares every output beat in order. A directed table covers zero divisors,
// the most negative value and sign combinations; random traffic follows under
// four idle/stall mixes, with a full drain between mixes.
// ----------------------------------------------------------------------------
module signed_restoring_divider_tb;
	import srd_pkg::*;

	localparam int W = 32;
	localparam int PIPE_DEPTH = W + 2;
	localparam int STALL_LIMIT = 5000;
	localparam int BEATS_PER_PHASE = 300;
	localparam int NUM_PHASES = 4;

	localparam logic [W-1:0] ZERO     = '0;
	localparam logic [W-1:0] ONE      = {{(W-1){1'b0}}, 1'b1};
	localparam logic [W-1:0] ALL_ONES = '1;
	localparam logic [W-1:0] MOST_NEG = {1'b1, {(W-1){1'b0}}};
	localparam logic [W-1:0] MOST_POS = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		logic [W-1:0] quotient;
		logic         div_by_zero;
	} quot_beat_t;

	// one directed row: operands, and the answer where it is obvious
	typedef struct packed {
		logic [W-1:0] num;
		logic [W-1:0] den;
		logic         fixed;
		logic [W-1:0] quotient;
		logic         div_by_zero;
	} div_case_t;

	localparam int NUM_CASES = 24;
	localparam div_case_t DIV_CASES [NUM_CASES] = '{
		// zero divisor: magnitude all ones, sign from the dividend alone
		'{ZERO,          ZERO, 1'b1, ALL_ONES, 1'b1},
		'{32'd5,         ZERO, 1'b1, ALL_ONES, 1'b1},
		'{32'hFFFF_FFFB, ZERO, 1'b1, ONE,      1'b1},
		'{MOST_NEG,      ZERO, 1'b1, ONE,      1'b1},
		'{MOST_POS,      ZERO, 1'b1, ALL_ONES, 1'b1},
		// extreme values: most negative over minus one wraps back to itself
		'{MOST_NEG, ALL_ONES, 1'b1, MOST_NEG,     1'b0},
		'{MOST_NEG, ONE,      1'b1, MOST_NEG,     1'b0},
		'{MOST_POS, ONE,      1'b1, MOST_POS,     1'b0},
		'{MOST_POS, ALL_ONES, 1'b1, MOST_NEG + 1, 1'b0},
		'{MOST_NEG, MOST_NEG, 1'b1, ONE,          1'b0},
		'{MOST_POS, MOST_POS, 1'b1, ONE,          1'b0},
		'{MOST_POS, MOST_NEG, 1'b1, ZERO,         1'b0},
		'{MOST_NEG, MOST_POS, 1'b1, ALL_ONES,     1'b0},
		'{ZERO,     ONE,      1'b1, ZERO,         1'b0},
		'{ALL_ONES, ALL_ONES, 1'b1, ONE,          1'b0},
		// truncation toward zero in all four sign quadrants, then mixed-size operands
		'{32'd7,         32'd2,         1'b0, ZERO, 1'b0},
		'{32'hFFFF_FFF9, 32'd2,         1'b0, ZERO, 1'b0},
		'{32'd7,         32'hFFFF_FFFE, 1'b0, ZERO, 1'b0},
		'{32'hFFFF_FFF9, 32'hFFFF_FFFE, 1'b0, ZERO, 1'b0},
		'{ONE,           MOST_NEG,      1'b0, ZERO, 1'b0},
		'{32'h5555_5555, 32'd3,         1'b0, ZERO, 1'b0},
		'{32'hAAAA_AAAA, 32'h0001_0000, 1'b0, ZERO, 1'b0},
		'{32'h7FFF_FFFF, 32'h0000_FFFF, 1'b0, ZERO, 1'b0},
		'{32'hDEAD_BEEF, 32'hFFFF_FF00, 1'b0, ZERO, 1'b0}
	};

	logic         clk;
	logic         arst_n;
	logic         in_valid;
	logic         in_stall;
	logic [W-1:0] dividend;
	logic [W-1:0] divisor;
	logic         out_valid;
	logic         out_stall;
	logic [W-1:0] quotient;
	logic         div_by_zero;

	quot_beat_t quotients_due [$];
	int         mismatches;
	int         quiet_cycles;
	int         send_idle_pct;
	int         recv_stall_pct;

	signed_restoring_divider #(.WIDTH(W)) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.dividend   (dividend),
		.divisor    (divisor),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.quotient   (quotient),
		.div_by_zero(div_by_zero)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Bit-serial restoring divide on magnitudes, sign applied afterwards.
	// A zero divisor lets every trial subtract succeed: all-ones magnitude.
	function automatic quot_beat_t divide_signed(logic [W-1:0] num, logic [W-1:0] den);
		logic [W-1:0] num_mag;
		logic [W-1:0] den_mag;
		logic [W-1:0] q_mag;
		logic [W:0]   partial;
		quot_beat_t   beat;
		int           bit_idx;
		num_mag = num[W-1] ? -num : num;
		den_mag = den[W-1] ? -den : den;
		partial = '0;
		q_mag = '0;
		for (bit_idx = W - 1; bit_idx >= 0; bit_idx--) begin
			partial = {partial[W-1:0], num_mag[bit_idx]};
			if (partial >= {1'b0, den_mag}) begin
				partial = partial - {1'b0, den_mag};
				q_mag[bit_idx] = 1'b1;
			end
		end
		beat.quotient = (num[W-1] ^ den[W-1]) ? -q_mag : q_mag;
		beat.div_by_zero = (den == ZERO);
		return beat;
	endfunction

	function automatic logic [W-1:0] random_dividend();
		logic [W-1:0] val;
		case ($urandom_range(0, 3))
			0: begin
				val = $urandom;
			end
			1: begin
				val = W'($signed($urandom_range(0, 511)) - 256);
			end
			2: begin
				case ($urandom_range(0, 3))
					0: val = MOST_NEG;
					1: val = MOST_POS;
					2: val = ZERO;
					default: val = ALL_ONES;
				endcase
			end
			default: begin
				val = W'($urandom) >> $urandom_range(0, W - 1);
				if ($urandom_range(0, 1))
					val = -val;
			end
		endcase
		return val;
	endfunction

	// divisor sizes spread out so the quotient length varies widely
	function automatic logic [W-1:0] random_divisor();
		logic [W-1:0] val;
		case ($urandom_range(0, 7))
			0: begin
				val = $urandom;
			end
			1: begin
				val = ZERO;
			end
			2: begin
				val = $urandom_range(0, 1) ? ONE : ALL_ONES;
			end
			3: begin
				val = W'($urandom_range(1, 16));
				if ($urandom_range(0, 1))
					val = -val;
			end
			default: begin
				val = W'($urandom) >> $urandom_range(0, W - 1);
				if ($urandom_range(0, 1))
					val = -val;
			end
		endcase
		return val;
	endfunction

	task automatic report_mismatch(string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// Offer one beat, after a random idle spell, and hold it until taken.
	task automatic offer_operands(logic [W-1:0] num, logic [W-1:0] den,
			logic fixed, quot_beat_t known);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		quotients_due.push_back(fixed ? known : divide_signed(num, den));
		in_valid <= 1'b1;
		dividend <= num;
		divisor <= den;
		do
			@(posedge clk);
		while (in_stall);
	endtask

	// Lower valid and let every outstanding quotient come out.
	task automatic drain_pipe();
		in_valid <= 1'b0;
		@(posedge clk);
		while (quotients_due.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Output side: each taken beat against the oldest expectation.
	always @(posedge clk) begin
		quot_beat_t due;
		if (arst_n && out_valid && !out_stall) begin
			if (quotients_due.size() == 0) begin
				report_mismatch($sformatf("quotient %h with nothing outstanding", quotient));
			end else begin
				due = quotients_due.pop_front();
				if (quotient !== due.quotient)
					report_mismatch($sformatf("quotient %h, wanted %h",
						quotient, due.quotient));
				if (div_by_zero !== due.div_by_zero)
					report_mismatch($sformatf("div_by_zero %b, wanted %b",
						div_by_zero, due.div_by_zero));
			end
		end
	end

	// Watchdog: too long with no beat moving on either side.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= STALL_LIMIT) begin
					$display("CHECK FAILED");
					$finish;
				end
			end
		end
	end

	initial begin
		int phase;
		int beat_idx;
		// sender idle / receiver stall percentages per phase
		int idle_mix [NUM_PHASES];
		int stall_mix [NUM_PHASES];
		idle_mix = '{0, 62, 0, 12};
		stall_mix = '{0, 0, 62, 12};
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		dividend = '0;
		divisor = '0;
		out_stall = 1'b0;
		mismatches = 0;
		quiet_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table, back to back
		for (beat_idx = 0; beat_idx < NUM_CASES; beat_idx++)
			offer_operands(DIV_CASES[beat_idx].num, DIV_CASES[beat_idx].den,
				DIV_CASES[beat_idx].fixed,
				'{DIV_CASES[beat_idx].quotient, DIV_CASES[beat_idx].div_by_zero});
		drain_pipe();

		// random traffic, pipe fully drained between mixes
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			send_idle_pct = idle_mix[phase];
			recv_stall_pct = stall_mix[phase];
			for (beat_idx = 0; beat_idx < BEATS_PER_PHASE; beat_idx++)
				offer_operands(random_dividend(), random_divisor(), 1'b0, '0);
			drain_pipe();
		end

		recv_stall_pct = 0;
		repeat (PIPE_DEPTH + 4) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[signed_restoring_divider.f]
hw/rtl/srd_pkg.sv
hw/rtl/srd_cell.sv
hw/rtl/signed_restoring_divider.sv
hw/rtl/srd_checker.sv
tb/signed_restoring_divider_tb.sv
